FILE: src/scvs_pkg.sv
// scvs_pkg: shared constants, types and helpers for the second-chance victim select block
// depends on nothing; used by scvs_front, scvs_back, second_chance_victim_select, scvs_checker and the testbench
package scvs_pkg;

	localparam int NUM_SETS   = 64;
	localparam int NUM_WAYS   = 8;
	localparam int STAMP_BITS = 32;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	localparam int CQ_DEPTH = 2;
	localparam int RQ_DEPTH = 2;

	localparam logic [1:0] FUNC_INVAL  = 2'd0;
	localparam logic [1:0] FUNC_TOUCH  = 2'd1;
	localparam logic [1:0] FUNC_INSERT = 2'd2;
	localparam logic [1:0] FUNC_VICTIM = 2'd3;

	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [SET_W-1:0] set_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [NUM_WAYS-1:0][STAMP_BITS-1:0] row_stamp_t;
	typedef logic [NUM_WAYS-1:0] row_bit_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_INVAL,
		K_TOUCH,
		K_INSERT,
		K_VICTIM
	} kind_t;

	typedef struct packed {
		kind_t  kind;
		set_t   set;
		way_t   way;
		stamp_t stamp;
	} cmd_t;

	typedef struct packed {
		logic [2:0] vway;
		logic       vinv;
		logic       done;
	} res_t;

	// set index modulo NUM_SETS, a power of two, so a mask
	function automatic set_t set_wrap(logic [5:0] idx);
		return SET_W'(idx & 6'(NUM_SETS - 1));
	endfunction

endpackage

FILE: src/scvs_front.sv
// scvs_front: accepts requests, decodes them into commands and queues them for the back end
// depends on scvs_pkg
module scvs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        func,
	input  logic [5:0]        set_index,
	input  logic [2:0]        way_index,
	input  logic [31:0]       now,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output scvs_pkg::cmd_t    cmd
);
	import scvs_pkg::*;

	localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CW = $clog2(CQ_DEPTH + 1);

	cmd_t            cmd_in;
	logic            way_ok;
	logic            push_fire;
	logic            pop_fire;
	cmd_t            cq_q [CQ_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;

	// decode
	always_comb begin
		way_ok       = 32'(way_index) < 32'(NUM_WAYS);
		cmd_in.set   = set_wrap(set_index);
		cmd_in.way   = WAY_W'(way_index);
		cmd_in.stamp = STAMP_BITS'(now);
		case (func)
			FUNC_INVAL:  cmd_in.kind = way_ok ? K_INVAL : K_NOP;
			FUNC_TOUCH:  cmd_in.kind = way_ok ? K_TOUCH : K_NOP;
			FUNC_INSERT: cmd_in.kind = way_ok ? K_INSERT : K_NOP;
			FUNC_VICTIM: cmd_in.kind = K_VICTIM;
			default:     cmd_in.kind = K_NOP;
		endcase
	end

	assign full      = cnt_q == CW'(CQ_DEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = cq_q[rptr_q];
	assign push_fire = push && !full;
	assign pop_fire  = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			cq_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_fire) begin
				wptr_q <= (wptr_q == PW'(CQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop_fire) begin
				rptr_q <= (rptr_q == PW'(CQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: src/scvs_back.sv
// scvs_back: per-set stamp and chance-bit stores, command engine and result queue
// depends on scvs_pkg; takes commands from scvs_front
module scvs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  scvs_pkg::cmd_t    cmd,
	output logic              empty,
	input  logic              pop,
	output scvs_pkg::res_t    res
);
	import scvs_pkg::*;

	localparam int PW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
	localparam int CW = $clog2(RQ_DEPTH + 1);
	localparam way_t LAST_WAY = WAY_W'(NUM_WAYS - 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LD    = 6'b000010,
		S_EXEC  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_CHECK = 6'b010000,
		S_WB    = 6'b100000
	} state_t;

	state_t            state_q;
	row_stamp_t        stamp_mem [NUM_SETS];
	row_bit_t          bit_mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_vld_q;
	cmd_t              cmd_q;
	row_stamp_t        rd_stamp_q;
	row_bit_t          rd_bit_q;
	logic              rd_vld_q;
	row_stamp_t        buf_stamp_q;
	row_bit_t          buf_bit_q;
	way_t              scan_q;
	stamp_t            min_q;
	way_t              min_idx_q;
	logic              first_q;
	res_t              pend_q;
	stamp_t            cur_s;
	logic              cur_b;
	logic              inv_hit;
	logic              wb_fire;
	logic              out_fire;
	res_t              rq_q [RQ_DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [CW-1:0]     cnt_q;

	assign cur_s    = buf_stamp_q[scan_q];
	assign cur_b    = buf_bit_q[scan_q];
	assign inv_hit  = first_q && (cur_s == '0) && !cur_b;
	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign wb_fire  = (state_q == S_WB) && (cnt_q != CW'(RQ_DEPTH));
	assign empty    = cnt_q == '0;
	assign out_fire = pop && !empty;
	assign res      = rq_q[rptr_q];

	// row stores
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			rd_stamp_q <= stamp_mem[cmd.set];
			rd_bit_q   <= bit_mem[cmd.set];
			rd_vld_q   <= row_vld_q[cmd.set];
		end
		if (wb_fire) begin
			stamp_mem[cmd_q.set] <= buf_stamp_q;
			bit_mem[cmd_q.set]   <= buf_bit_q;
		end
	end

	// working row and search
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			S_LD: begin
				buf_stamp_q <= rd_vld_q ? rd_stamp_q : '0;
				buf_bit_q   <= rd_vld_q ? rd_bit_q : '0;
				scan_q      <= '0;
				first_q     <= 1'b1;
				pend_q      <= '{vway: 3'd0, vinv: 1'b0, done: 1'b1};
			end
			S_EXEC: begin
				case (cmd_q.kind)
					K_INVAL: begin
						buf_stamp_q[cmd_q.way] <= '0;
						buf_bit_q[cmd_q.way]   <= 1'b0;
					end
					K_TOUCH: begin
						buf_bit_q[cmd_q.way] <= 1'b1;
					end
					K_INSERT: begin
						buf_stamp_q[cmd_q.way] <= cmd_q.stamp;
						buf_bit_q[cmd_q.way]   <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if ((scan_q == '0) || (cur_s < min_q)) begin
					min_q     <= cur_s;
					min_idx_q <= scan_q;
				end
				if (inv_hit) begin
					pend_q.vway <= 3'(scan_q);
					pend_q.vinv <= 1'b1;
				end
				scan_q <= scan_q + WAY_W'(1);
			end
			S_CHECK: begin
				if (buf_bit_q[min_idx_q]) begin
					// rescue: clear the bit and restamp
					buf_bit_q[min_idx_q]   <= 1'b0;
					buf_stamp_q[min_idx_q] <= cmd_q.stamp;
					first_q                <= 1'b0;
					scan_q                 <= '0;
				end else begin
					pend_q.vway <= 3'(min_idx_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_vld_q <= '0;
		end else begin
			if (wb_fire) begin
				row_vld_q[cmd_q.set] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_LD;
					end
				end
				S_LD: begin
					state_q <= (cmd_q.kind == K_VICTIM) ? S_SCAN : S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_WB;
				end
				S_SCAN: begin
					if (inv_hit) begin
						state_q <= S_WB;
					end else if (scan_q == LAST_WAY) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= buf_bit_q[min_idx_q] ? S_SCAN : S_WB;
				end
				S_WB: begin
					if (wb_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (wb_fire) begin
			rq_q[wptr_q] <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wb_fire) begin
				wptr_q <= (wptr_q == PW'(RQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (out_fire) begin
				rptr_q <= (rptr_q == PW'(RQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (wb_fire && !out_fire) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (out_fire && !wb_fire) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: src/second_chance_victim_select.sv
// updates (invalidate, touch, insert) pass through the load, execute and write-back states
// victim: load, then scan passes each ending in a check, up to NUM_WAYS + 1 passes;
// an invalid way k found in the first pass ends the search and goes to write-back
// the back end works on one request at a time and scans one way per cycle
// front queue holds 2 requests, result queue holds 2 results
// reset: queues and engine clear asynchronously; per-set valid flags make the stores read as zero
module second_chance_victim_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [5:0]  set_index,
	input  logic [2:0]  way_index,
	input  logic [31:0] now,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  victim_way,
	output logic        victim_was_invalid,
	output logic        op_done
);
	import scvs_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;
	res_t res;

	scvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.set_index (set_index),
		.way_index (way_index),
		.now       (now),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	scvs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign victim_way         = res.vway;
	assign victim_was_invalid = res.vinv;
	assign op_done            = res.done;

`ifndef ASSERT_OFF
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from empty queue");

	a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !cmd_pop)
		else $error("back end took two commands in a row");

	a_full_keeps_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> cmd_valid)
		else $error("full command queue drained in one cycle");
`endif

endmodule

FILE: sim/scvs_checker.sv
`timescale 1ns / 1ps
// scvs_checker: watches the request and result queues of second_chance_victim_select,
// keeps its own copy of the stamps and second-chance bits, predicts every result and compares
// depends on scvs_pkg for widths, function codes and the result type
module scvs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  func,
	input  logic [5:0]  set_index,
	input  logic [2:0]  way_index,
	input  logic [31:0] now,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  victim_way,
	input  logic        victim_was_invalid,
	input  logic        op_done,
	output int          fail_count,
	output int          pending,
	output int          results_checked,
	output int          victim_searches,
	output int          invalid_picks,
	output int          rescues
);
	import scvs_pkg::*;

	localparam int ENTRIES = NUM_SETS * NUM_WAYS;

	stamp_t way_stamp [ENTRIES];
	logic   way_chance [ENTRIES];
	res_t   due_results [$];

	// next result for one request, updating the stamps and bits on the way
	function automatic res_t replace_step(logic [1:0] f, logic [5:0] s, logic [2:0] w,
			logic [31:0] t);
		res_t   r;
		int     base;
		int     oldest;
		bit     found;
		stamp_t t_now;
		r = '0;
		r.done = 1'b1;
		t_now = stamp_t'(t);
		base = (int'(s) % NUM_SETS) * NUM_WAYS;
		found = 1'b0;
		if (f == FUNC_VICTIM) begin
			victim_searches++;
			for (int k = 0; k < NUM_WAYS && !found; k++) begin
				if (way_stamp[base + k] == '0 && !way_chance[base + k]) begin
					r.vway = 3'(k);
					r.vinv = 1'b1;
					found = 1'b1;
					invalid_picks++;
				end
			end
			for (int n = 0; n <= NUM_WAYS && !found; n++) begin
				oldest = 0;
				for (int k = 1; k < NUM_WAYS; k++) begin
					if (way_stamp[base + k] < way_stamp[base + oldest]) begin
						oldest = k;
					end
				end
				if (!way_chance[base + oldest]) begin
					r.vway = 3'(oldest);
					found = 1'b1;
				end else begin
					way_chance[base + oldest] = 1'b0;
					way_stamp[base + oldest] = t_now;
					rescues++;
				end
			end
		end else if (int'(w) < NUM_WAYS) begin
			case (f)
				FUNC_INVAL: begin
					way_stamp[base + w] = '0;
					way_chance[base + w] = 1'b0;
				end
				FUNC_TOUCH: begin
					way_chance[base + w] = 1'b1;
				end
				default: begin
					way_stamp[base + w] = t_now;
					way_chance[base + w] = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				way_stamp[i] = '0;
				way_chance[i] = 1'b0;
			end
			due_results.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			victim_searches = 0;
			invalid_picks = 0;
			rescues = 0;
		end else begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$error("result with no request waiting: way %0d invalid %0b done %0b",
						victim_way, victim_was_invalid, op_done);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					results_checked++;
					if (victim_way !== want.vway) begin
						$error("victim_way: expected %0d, got %0d", want.vway, victim_way);
						fail_count++;
					end
					if (victim_was_invalid !== want.vinv) begin
						$error("victim_was_invalid: expected %0b, got %0b", want.vinv,
							victim_was_invalid);
						fail_count++;
					end
					if (op_done !== want.done) begin
						$error("op_done: expected %0b, got %0b", want.done, op_done);
						fail_count++;
					end
				end
			end
			if (push && !full) begin
				due_results.push_back(replace_step(func, set_index, way_index, now));
			end
			pending = due_results.size();
		end
	end

endmodule

FILE: sim/tb_second_chance_victim_select.sv
`timescale 1ns / 1ps
// tb_second_chance_victim_select: drives directed and random requests into
// second_chance_victim_select with random idling on both queues and reports the verdict
// depends on scvs_pkg, second_chance_victim_select and scvs_checker
module tb_second_chance_victim_select;
	import scvs_pkg::*;

	localparam int RANDOM_REQS = 700;
	localparam int CALM_REQS   = 100;
	localparam int LIMIT       = 400000;
	localparam int DRAIN       = 120;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  func;
	logic [5:0]  set_index;
	logic [2:0]  way_index;
	logic [31:0] now;
	logic        empty;
	logic        pop;
	logic [2:0]  victim_way;
	logic        victim_was_invalid;
	logic        op_done;

	int fail_count;
	int pending;
	int results_checked;
	int victim_searches;
	int invalid_picks;
	int rescues;
	int req_count;
	int cycle_count;
	bit calm;

	second_chance_victim_select i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.func               (func),
		.set_index          (set_index),
		.way_index          (way_index),
		.now                (now),
		.empty              (empty),
		.pop                (pop),
		.victim_way         (victim_way),
		.victim_was_invalid (victim_was_invalid),
		.op_done            (op_done)
	);

	scvs_checker i_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.func               (func),
		.set_index          (set_index),
		.way_index          (way_index),
		.now                (now),
		.empty              (empty),
		.pop                (pop),
		.victim_way         (victim_way),
		.victim_was_invalid (victim_was_invalid),
		.op_done            (op_done),
		.fail_count         (fail_count),
		.pending            (pending),
		.results_checked    (results_checked),
		.victim_searches    (victim_searches),
		.invalid_picks      (invalid_picks),
		.rescues            (rescues)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// one request, held until the block takes it
	task automatic send_req(input logic [1:0] f, input logic [5:0] s, input logic [2:0] w,
			input logic [31:0] t);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		func <= f;
		set_index <= s;
		way_index <= w;
		now <= t;
		do @(posedge clk); while (full);
		req_count++;
		@(negedge clk);
	endtask

	initial begin
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				gap = $urandom_range(1, 13);
				repeat (gap - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		logic [1:0]  f;
		logic [5:0]  s;
		logic [2:0]  w;
		logic [31:0] t;
		logic [31:0] tick;
		int          pick;
		arst_n = 1'b0;
		push = 1'b0;
		func = FUNC_INVAL;
		set_index = '0;
		way_index = '0;
		now = '0;
		calm = 1'b0;
		req_count = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty set, max stamp, insert at time zero
		send_req(FUNC_VICTIM, 6'd0, 3'd0, 32'd7);
		send_req(FUNC_INSERT, 6'd63, 3'd7, 32'hFFFF_FFFF);
		send_req(FUNC_INSERT, 6'd63, 3'd0, 32'd0);
		send_req(FUNC_VICTIM, 6'd63, 3'd5, 32'd9);
		// full set with a tie on the oldest stamp
		for (int k = 0; k < NUM_WAYS; k++) begin
			send_req(FUNC_INSERT, 6'd5, 3'(k), (k == 2 || k == 5) ? 32'd40 : 32'(100 + k));
		end
		send_req(FUNC_TOUCH, 6'd5, 3'd2, 32'd0);
		send_req(FUNC_TOUCH, 6'd5, 3'd5, 32'd0);
		send_req(FUNC_VICTIM, 6'd5, 3'd0, 32'd300);
		// every way gets a second chance
		for (int k = 0; k < NUM_WAYS; k++) begin
			send_req(FUNC_TOUCH, 6'd5, 3'(k), 32'hA5A5_5A5A);
		end
		send_req(FUNC_VICTIM, 6'd5, 3'd0, 32'd500);
		send_req(FUNC_INVAL, 6'd5, 3'd4, 32'd0);
		send_req(FUNC_VICTIM, 6'd5, 3'd0, 32'd600);

		tick = 32'($urandom_range(1, 1000));
		for (int n = 0; n < RANDOM_REQS; n++) begin
			calm = (n >= RANDOM_REQS - CALM_REQS);
			pick = $urandom_range(0, 99);
			s = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
			w = 3'($urandom);
			if (pick < 12) begin
				f = 2'($urandom);
				case ($urandom_range(0, 3))
					0: t = 32'd0;
					1: t = 32'hFFFF_FFFF;
					default: t = $urandom;
				endcase
			end else begin
				tick = tick + 32'($urandom_range(0, 3));
				t = tick;
				if (pick < 52) begin
					f = FUNC_INSERT;
				end else if (pick < 77) begin
					f = FUNC_TOUCH;
				end else if (pick < 90) begin
					f = FUNC_VICTIM;
				end else begin
					f = FUNC_INVAL;
				end
				if (pick >= 77 && pick < 90 && $urandom_range(0, 1) == 0) begin
					f = FUNC_VICTIM;
				end
			end
			send_req(f, s, w, t);
		end
		push <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("ran %0d requests, %0d results checked, %0d failures", req_count,
			results_checked, fail_count);
		$display("victim searches %0d: %0d took an invalid way, %0d second chances given",
			victim_searches, invalid_picks, rescues);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/scvs_pkg.sv
src/scvs_front.sv
src/scvs_back.sv
src/second_chance_victim_select.sv
sim/scvs_checker.sv
sim/tb_second_chance_victim_select.sv
